[rtl/dotd_pkg.sv]
// shared types, constants and calendar helpers for the day offset to date block
// no dependencies
`default_nettype none

package dotd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned IDX_W   = 2;

  // register indexes on the config port
  localparam logic [IDX_W-1:0] REG_BASE_DAY   = 2'd0;
  localparam logic [IDX_W-1:0] REG_BASE_MONTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE_YEAR  = 2'd2;

  localparam logic [DAY_W-1:0]   RST_BASE_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] RST_BASE_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0]  RST_BASE_YEAR  = 14'd2018;

  localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DOY_W-1:0] DAYS_YEAR = 9'd365;
  localparam logic [DOY_W-1:0] DAYS_LEAP = 9'd366;

  // year / 100 as (year * DIV100_MUL) >> DIV100_SHIFT, exact for year < 43690
  localparam int unsigned     DIV100_SHIFT = 20;
  localparam int unsigned     PROD_W       = YEAR_W + 14;
  localparam logic [13:0]     DIV100_MUL   = 14'd10486;
  localparam logic [6:0]      CENT_LAST    = 7'd99;
  localparam logic [YEAR_W-1:0] CENT       = 14'd100;

  typedef struct packed {
    logic load;
    logic mult;
    logic mods;
    logic doy;
    logic year_step;
    logic month_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_year;
    logic year_more;
    logic month_more;
  } status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // days in the months before month m
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/day_offset_to_date.sv]
// sequence: accept, setup states MULT, MODS and DOY, then year steps (none when the offset stays
// in the base year), month steps (at most 11 months stepped) and a result state that waits for
// the output register. throughput: one item at a time, set by the shared year/month stepper
// reset: async active low, clears control and loads base date 1 jan 2018
// depends on dotd_pkg, dotd_ctrl and dotd_dp
`default_nettype none

module day_offset_to_date #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config port
  input  wire logic                          cfg_we_i,
  input  wire logic [dotd_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dotd_pkg::CFG_W-1:0]    cfg_wdata_i,
  // input item
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [OFFSET_WIDTH-1:0]       day_offset_i,
  // result item
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [dotd_pkg::DAY_W-1:0]         day_o,
  output logic [dotd_pkg::MONTH_W-1:0]       month_o,
  output logic [dotd_pkg::YEAR_W-1:0]        year_o
);

  logic [dotd_pkg::DAY_W-1:0]   base_day_q,   base_day_d;
  logic [dotd_pkg::MONTH_W-1:0] base_month_q, base_month_d;
  logic [dotd_pkg::YEAR_W-1:0]  base_year_q,  base_year_d;

  dotd_pkg::cmd_t    cmd;
  dotd_pkg::status_t status;

  // base date registers, raw values; year and month are clamped when an item is loaded, the day at the doy step
  always_comb begin
    base_day_d   = base_day_q;
    base_month_d = base_month_q;
    base_year_d  = base_year_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dotd_pkg::REG_BASE_DAY:   base_day_d   = cfg_wdata_i[dotd_pkg::DAY_W-1:0];
        dotd_pkg::REG_BASE_MONTH: base_month_d = cfg_wdata_i[dotd_pkg::MONTH_W-1:0];
        dotd_pkg::REG_BASE_YEAR:  base_year_d  = cfg_wdata_i[dotd_pkg::YEAR_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_day_q   <= dotd_pkg::RST_BASE_DAY;
      base_month_q <= dotd_pkg::RST_BASE_MONTH;
      base_year_q  <= dotd_pkg::RST_BASE_YEAR;
    end else begin
      base_day_q   <= base_day_d;
      base_month_q <= base_month_d;
      base_year_q  <= base_year_d;
    end
  end

  // sequencer: one item in flight, result held in the output register
  dotd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // calendar arithmetic
  dotd_dp #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .day_offset_i (day_offset_i),
    .base_day_i   (base_day_q),
    .base_month_i (base_month_q),
    .base_year_i  (base_year_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .day_o        (day_o),
    .month_o      (month_o),
    .year_o       (year_o)
  );

endmodule

`default_nettype wire

[rtl/dotd_ctrl.sv]
// sequencing state machine for the day offset to date block
// depends on dotd_pkg for the command and status structs
`default_nettype none

module dotd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire dotd_pkg::status_t status_i,
  output dotd_pkg::cmd_t        cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MULT   = 7'b0000010,
    S_MODS   = 7'b0000100,
    S_DOY    = 7'b0001000,
    S_YEARS  = 7'b0010000,
    S_MONTHS = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MULT;
        end
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_MODS;
      end
      S_MODS: begin
        cmd_o.mods = 1'b1;
        state_d    = S_DOY;
      end
      S_DOY: begin
        cmd_o.doy = 1'b1;
        state_d   = status_i.in_year ? S_MONTHS : S_YEARS;
      end
      S_YEARS: begin
        cmd_o.year_step = 1'b1;
        if (!status_i.year_more) begin
          state_d = S_MONTHS;
        end
      end
      S_MONTHS: begin
        cmd_o.month_step = 1'b1;
        if (!status_i.month_more) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/dotd_dp.sv]
// datapath: base date clamp, day of year, year and month stepping, result register
// depends on dotd_pkg for widths, calendar helpers and command/status structs
`default_nettype none

module dotd_dp #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [OFFSET_WIDTH-1:0]       day_offset_i,
  input  wire logic [dotd_pkg::DAY_W-1:0]    base_day_i,
  input  wire logic [dotd_pkg::MONTH_W-1:0]  base_month_i,
  input  wire logic [dotd_pkg::YEAR_W-1:0]   base_year_i,
  input  wire dotd_pkg::cmd_t                cmd_i,
  output dotd_pkg::status_t                  status_o,
  output logic [dotd_pkg::DAY_W-1:0]         day_o,
  output logic [dotd_pkg::MONTH_W-1:0]       month_o,
  output logic [dotd_pkg::YEAR_W-1:0]        year_o
);

  localparam int unsigned DW = dotd_pkg::DOY_W;

  logic [OFFSET_WIDTH-1:0]          x_q;
  logic [dotd_pkg::YEAR_W-1:0]      y_q;
  logic [dotd_pkg::MONTH_W-1:0]     m_q;
  logic [DW-1:0]                    t_q;
  logic [dotd_pkg::PROD_W-1:0]      prod_q;
  logic [6:0]                       r100_q;   // year mod 100
  logic [1:0]                       q4_q;     // (year / 100) mod 4
  logic [dotd_pkg::DAY_W-1:0]       day_q;
  logic [dotd_pkg::MONTH_W-1:0]     month_q;
  logic [dotd_pkg::YEAR_W-1:0]      year_q;

  logic                             leap;
  logic [DW-1:0]                    ylen;
  logic [dotd_pkg::DAY_W-1:0]       mlen;
  logic [dotd_pkg::DAY_W-1:0]       d0c;
  logic [DW-1:0]                    doy;
  logic [DW-1:0]                    rem;
  logic [dotd_pkg::YEAR_W-1:0]      y0c;
  logic [dotd_pkg::MONTH_W-1:0]     m0c;
  logic [7:0]                       cent;
  logic [dotd_pkg::YEAR_W-1:0]      cent_x100;

  // leap rule from the tracked residues
  assign leap = ((y_q[1:0] == 2'd0) && (r100_q != 7'd0)) ||
                ((r100_q == 7'd0) && (q4_q == 2'd0));
  assign ylen = leap ? dotd_pkg::DAYS_LEAP : dotd_pkg::DAYS_YEAR;
  assign mlen = dotd_pkg::month_len(m_q, leap);

  // base day clamp; t_q holds the raw base day until the doy step
  always_comb begin
    if (t_q[dotd_pkg::DAY_W-1:0] == '0) begin
      d0c = 5'd1;
    end else if (t_q[dotd_pkg::DAY_W-1:0] > mlen) begin
      d0c = mlen;
    end else begin
      d0c = t_q[dotd_pkg::DAY_W-1:0];
    end
  end

  assign doy = dotd_pkg::days_before(m_q, leap) + DW'(d0c);
  assign rem = ylen - doy;

  always_comb begin
    if (base_year_i < dotd_pkg::YEAR_MIN) begin
      y0c = dotd_pkg::YEAR_MIN;
    end else if (base_year_i > dotd_pkg::YEAR_MAX) begin
      y0c = dotd_pkg::YEAR_MAX;
    end else begin
      y0c = base_year_i;
    end
    if (base_month_i < dotd_pkg::MONTH_JAN) begin
      m0c = dotd_pkg::MONTH_JAN;
    end else if (base_month_i > dotd_pkg::MONTH_DEC) begin
      m0c = dotd_pkg::MONTH_DEC;
    end else begin
      m0c = base_month_i;
    end
  end

  assign cent      = prod_q[dotd_pkg::DIV100_SHIFT +: 8];
  assign cent_x100 = dotd_pkg::YEAR_W'(cent) * dotd_pkg::CENT;

  assign status_o.in_year    = (x_q <= OFFSET_WIDTH'(rem));
  assign status_o.year_more  = (x_q > OFFSET_WIDTH'(ylen));
  assign status_o.month_more = (m_q < dotd_pkg::MONTH_DEC) && (t_q > DW'(mlen));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= day_offset_i;
      y_q <= y0c;
      m_q <= m0c;
      t_q <= DW'(base_day_i);
    end
    if (cmd_i.mult) begin
      prod_q <= dotd_pkg::PROD_W'(y_q) * dotd_pkg::PROD_W'(dotd_pkg::DIV100_MUL);
    end
    if (cmd_i.mods) begin
      r100_q <= 7'(y_q - cent_x100);
      q4_q   <= cent[1:0];
    end
    if (cmd_i.doy) begin
      m_q <= dotd_pkg::MONTH_JAN;
      if (status_o.in_year) begin
        t_q <= doy + DW'(x_q);
      end else begin
        x_q <= x_q - OFFSET_WIDTH'(rem);
      end
    end
    if (cmd_i.year_step) begin
      if (status_o.year_more) begin
        x_q <= x_q - OFFSET_WIDTH'(ylen);
      end else begin
        t_q <= DW'(x_q);
      end
    end
    // move into the next year, keeping the residues in step
    if ((cmd_i.doy && !status_o.in_year) || (cmd_i.year_step && status_o.year_more)) begin
      y_q <= y_q + 1'b1;
      if (r100_q == dotd_pkg::CENT_LAST) begin
        r100_q <= 7'd0;
        q4_q   <= q4_q + 1'b1;
      end else begin
        r100_q <= r100_q + 1'b1;
      end
    end
    if (cmd_i.month_step && status_o.month_more) begin
      t_q <= t_q - DW'(mlen);
      m_q <= m_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      day_q   <= t_q[dotd_pkg::DAY_W-1:0];
      month_q <= m_q;
      year_q  <= y_q;
    end
  end

  assign day_o   = day_q;
  assign month_o = month_q;
  assign year_o  = year_q;

endmodule

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for day_offset_to_date: a directed table, then random items
// under several idle/stall mixes, checked against a calendar predictor in this file
// depends on dotd_pkg and the day_offset_to_date rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // wait after the final drain, sized for the worst item and rounded up
  localparam int unsigned LATENCY = 250;
  // quiet cycles before giving up: one slow item plus long random stall and idle runs
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned N_PLAN = 25;
  localparam int unsigned BASES_PER_MIX = 7;
  localparam int unsigned ITEMS_PER_BASE = 62;

  typedef struct packed {
    logic [dotd_pkg::DAY_W-1:0]   day;
    logic [dotd_pkg::MONTH_W-1:0] month;
    logic [dotd_pkg::YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [15:0] offs;
    date_t       want;
  } pending_date_t;

  // one directed row: base date, offset, and a hand-typed date where it is obvious
  typedef struct packed {
    logic [dotd_pkg::DAY_W-1:0]   bd;
    logic [dotd_pkg::MONTH_W-1:0] bm;
    logic [dotd_pkg::YEAR_W-1:0]  by;
    logic [15:0]                  offs;
    logic                         pin;
    date_t                        want;
  } plan_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [dotd_pkg::IDX_W-1:0]    cfg_idx_i;
  logic [dotd_pkg::CFG_W-1:0]    cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [15:0]                   day_offset_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [dotd_pkg::DAY_W-1:0]    day_o;
  logic [dotd_pkg::MONTH_W-1:0]  month_o;
  logic [dotd_pkg::YEAR_W-1:0]   year_o;

  day_offset_to_date #(
    .OFFSET_WIDTH(16)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .day_offset_i(day_offset_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .day_o       (day_o),
    .month_o     (month_o),
    .year_o      (year_o)
  );

  // copy of the base date registers as last written
  logic [dotd_pkg::DAY_W-1:0]   base_day_q   = dotd_pkg::RST_BASE_DAY;
  logic [dotd_pkg::MONTH_W-1:0] base_month_q = dotd_pkg::RST_BASE_MONTH;
  logic [dotd_pkg::YEAR_W-1:0]  base_year_q  = dotd_pkg::RST_BASE_YEAR;

  pending_date_t pending_dates[$];
  int unsigned   errors = 0;
  int unsigned   n_items = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_bases = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;

  // a directed row with a typed date overrides the predictor while it is presented
  logic  pin_now = 1'b0;
  date_t pin_date = '0;

  // directed table: reset base first (no write), then clamps, month ends, leap rules
  plan_row_t plan [N_PLAN] = '{
    // reset base date, year boundary on both sides, offset extremes and bit patterns
    '{5'd1,  4'd1,  14'd2018,  16'd0,      1'b1, '{5'd1,  4'd1,  14'd2018}},
    '{5'd1,  4'd1,  14'd2018,  16'd364,    1'b1, '{5'd31, 4'd12, 14'd2018}},
    '{5'd1,  4'd1,  14'd2018,  16'd365,    1'b1, '{5'd1,  4'd1,  14'd2019}},
    '{5'd1,  4'd1,  14'd2018,  16'hFFFF,   1'b0, '0},
    '{5'd1,  4'd1,  14'd2018,  16'hAAAA,   1'b0, '0},
    '{5'd1,  4'd1,  14'd2018,  16'h5555,   1'b0, '0},
    // all registers zero clamp up to 1 jan of year 1
    '{5'd0,  4'd0,  14'd0,     16'd0,      1'b1, '{5'd1,  4'd1,  14'd1}},
    '{5'd0,  4'd0,  14'd0,     16'hFFFF,   1'b0, '0},
    // all registers at full scale clamp down to 31 dec 9999
    '{5'd31, 4'd15, 14'd16383, 16'd0,      1'b1, '{5'd31, 4'd12, 14'd9999}},
    '{5'd31, 4'd15, 14'd16383, 16'hFFFF,   1'b0, '0},
    // year just past the top clamps, then rolls into year 10000
    '{5'd31, 4'd12, 14'd10000, 16'd1,      1'b1, '{5'd1,  4'd1,  14'd10000}},
    // day past the end of february, plain and leap years
    '{5'd31, 4'd2,  14'd2019,  16'd0,      1'b1, '{5'd28, 4'd2,  14'd2019}},
    '{5'd31, 4'd2,  14'd2019,  16'd1,      1'b1, '{5'd1,  4'd3,  14'd2019}},
    '{5'd30, 4'd2,  14'd2020,  16'd0,      1'b1, '{5'd29, 4'd2,  14'd2020}},
    '{5'd30, 4'd2,  14'd2020,  16'd1,      1'b1, '{5'd1,  4'd3,  14'd2020}},
    // century years: 1900 is not leap, 2000 is
    '{5'd29, 4'd2,  14'd1900,  16'd0,      1'b1, '{5'd28, 4'd2,  14'd1900}},
    '{5'd29, 4'd2,  14'd2000,  16'd0,      1'b1, '{5'd29, 4'd2,  14'd2000}},
    // day past the end of a 30 day month
    '{5'd31, 4'd4,  14'd2021,  16'd0,      1'b1, '{5'd30, 4'd4,  14'd2021}},
    // month register above december
    '{5'd15, 4'd13, 14'd2020,  16'd0,      1'b1, '{5'd15, 4'd12, 14'd2020}},
    // base on the last day of its year: nothing left in the base year
    '{5'd31, 4'd12, 14'd2018,  16'd0,      1'b1, '{5'd31, 4'd12, 14'd2018}},
    '{5'd31, 4'd12, 14'd2018,  16'd1,      1'b1, '{5'd1,  4'd1,  14'd2019}},
    '{5'd31, 4'd12, 14'd2018,  16'd366,    1'b1, '{5'd1,  4'd1,  14'd2020}},
    // leap base year, both sides of its end
    '{5'd1,  4'd1,  14'd2016,  16'd365,    1'b1, '{5'd31, 4'd12, 14'd2016}},
    '{5'd1,  4'd1,  14'd2016,  16'd366,    1'b1, '{5'd1,  4'd1,  14'd2017}},
    // 2100 is not leap: 28 feb runs straight into march
    '{5'd28, 4'd2,  14'd2100,  16'd1,      1'b1, '{5'd1,  4'd3,  14'd2100}}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned year_days(input int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      2:             n = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  // date that lies offs days after the current base date
  function automatic date_t date_after(input logic [15:0] offs);
    int unsigned m0, y0, d0, doy, left, x, y, t, m, i;
    date_t r;
    // clamp the base registers into a real date
    m0 = base_month_q;
    if (m0 < 1) m0 = 1;
    if (m0 > 12) m0 = 12;
    y0 = base_year_q;
    if (y0 < 1) y0 = 1;
    if (y0 > 9999) y0 = 9999;
    d0 = base_day_q;
    if (d0 < 1) d0 = 1;
    if (d0 > month_days(m0, y0)) d0 = month_days(m0, y0);
    doy = d0;
    for (i = 1; i < m0; i++) begin
      doy += month_days(i, y0);
    end
    // stay in the base year, or step whole years past it
    x = offs;
    left = year_days(y0) - doy;
    if (x <= left) begin
      y = y0;
      t = doy + x;
    end else begin
      x -= left;
      y = y0 + 1;
      while (x > year_days(y)) begin
        x -= year_days(y);
        y++;
      end
      t = x;
    end
    // walk the months
    m = 1;
    while (m < 12 && t > month_days(m, y)) begin
      t -= month_days(m, y);
      m++;
    end
    r.day   = t[dotd_pkg::DAY_W-1:0];
    r.month = m[dotd_pkg::MONTH_W-1:0];
    r.year  = y[dotd_pkg::YEAR_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors

  // every accepted item queues the date it should produce
  always @(posedge clk_i) begin : take_item
    pending_date_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      e.offs = day_offset_i;
      e.want = pin_now ? pin_date : date_after(day_offset_i);
      pending_dates.push_back(e);
      n_items++;
    end
  end

  // every accepted result is matched against the oldest queued date
  always @(posedge clk_i) begin : check_result
    pending_date_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0d/%0d/%0d with nothing pending",
                 $time, day_o, month_o, year_o);
      end else begin
        e = pending_dates.pop_front();
        n_checked++;
        if (day_o !== e.want.day || month_o !== e.want.month || year_o !== e.want.year) begin
          errors++;
          $display("%0t: offset %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d", $time,
                   e.offs, e.want.day, e.want.month, e.want.year, day_o, month_o, year_o);
        end
      end
    end
  end

  // watchdog: too long with no handshake on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver stalls at random, changing only on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- drivers

  // lower valid and wait until every queued date has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_dates.size() != 0);
  endtask

  // write the three base date registers back to back; call only while idle
  task automatic set_base(input logic [dotd_pkg::CFG_W-1:0] d,
                          input logic [dotd_pkg::CFG_W-1:0] m,
                          input logic [dotd_pkg::CFG_W-1:0] y);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= dotd_pkg::REG_BASE_DAY;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_idx_i   <= dotd_pkg::REG_BASE_MONTH;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_idx_i   <= dotd_pkg::REG_BASE_YEAR;
    cfg_wdata_i <= y;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    // registers keep only their low bits
    base_day_q   = d[dotd_pkg::DAY_W-1:0];
    base_month_q = m[dotd_pkg::MONTH_W-1:0];
    base_year_q  = y[dotd_pkg::YEAR_W-1:0];
    n_bases++;
  endtask

  // present one item, idling first at random; valid stays high on return
  task automatic send_item(input logic [15:0] offs, input logic pin, input date_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pin_now  = pin;
    pin_date = want;
    in_valid_i   <= 1'b1;
    day_offset_i <= offs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // offsets: full range, short spans, near year boundaries, extremes
  function automatic logic [15:0] pick_offset();
    int unsigned k, r;
    r = $urandom_range(9);
    k = $urandom_range(1, 179);
    case (r)
      0, 1, 2, 3: return 16'($urandom_range(65535));
      4, 5, 6:    return 16'($urandom_range(800));
      7, 8:       return 16'(365 * k + k / 4 + $urandom_range(4) - 2);
      default:    return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // random year register value: mostly sane, sometimes anything in the full field, or a century year
  function automatic logic [dotd_pkg::CFG_W-1:0] pick_year();
    case ($urandom_range(3))
      0:       return dotd_pkg::CFG_W'($urandom_range(16383));
      1:       return dotd_pkg::CFG_W'($urandom_range(1, 9999));
      2:       return dotd_pkg::CFG_W'($urandom_range(1580, 2400));
      default: return dotd_pkg::CFG_W'(1900 + 100 * $urandom_range(4));
    endcase
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int unsigned r, mix, s, k;
    logic [dotd_pkg::CFG_W-1:0] d, m, y;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = dotd_pkg::REG_BASE_DAY;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    day_offset_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, no idling; the base is rewritten only when a row changes it
    for (r = 0; r < N_PLAN; r++) begin
      if (plan[r].bd != base_day_q || plan[r].bm != base_month_q || plan[r].by != base_year_q)
      begin
        wait_idle();
        set_base(dotd_pkg::CFG_W'(plan[r].bd), dotd_pkg::CFG_W'(plan[r].bm), plan[r].by);
      end
      send_item(plan[r].offs, plan[r].pin, plan[r].want);
    end
    wait_idle();
    pin_now = 1'b0;

    // random part: four idle/stall mixes, each over several base dates
    for (mix = 0; mix < 4; mix++) begin
      case (mix)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 66; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (s = 0; s < BASES_PER_MIX; s++) begin
        // the first two base dates of each mix sit at the register extremes
        if (s == 0) begin
          d = '0;
          m = '0;
          y = '0;
        end else if (s == 1) begin
          d = dotd_pkg::CFG_W'(31);
          m = dotd_pkg::CFG_W'(15);
          y = dotd_pkg::CFG_W'(16383);
        end else begin
          d = dotd_pkg::CFG_W'($urandom_range(16383));
          m = dotd_pkg::CFG_W'($urandom_range(16383));
          y = pick_year();
        end
        wait_idle();
        set_base(d, m, y);
        for (k = 0; k < ITEMS_PER_BASE; k++) begin
          // now and then hold off until the block has drained
          if ($urandom_range(39) == 0) begin
            wait_idle();
          end
          send_item(pick_offset(), 1'b0, '0);
        end
      end
    end

    wait_idle();
    repeat (LATENCY) @(negedge clk_i);

    $display("tb: %0d items over %0d base dates (reset base included), %0d dates checked",
             n_items, n_bases + 1, n_checked);
    $display("tb: idle/stall mixes none, sender, receiver and both; base registers at extremes");
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      if (pending_dates.size() != 0) begin
        $display("%0t: %0d dates never came back", $time, pending_dates.size());
      end
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
